FILE: rtl/lph_pkg.sv
// lph_pkg: shared constants, types and helper functions for the linear probe hash table
// no dependencies; imported by every module of the block except lph_ram
`timescale 1ns / 1ps

package lph_pkg;

    // table geometry (slot count must be a power of two)
    localparam int TABLE_SLOTS  = 64;
    localparam int SLOT_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W        = SLOT_W + 1;

    // field widths
    localparam int KEY_W        = 32;
    localparam int HND_W        = 16;
    localparam int STATUS_W     = 3;
    localparam int SLOT_FIELD_W = 6;
    localparam int ENTRY_W      = KEY_W + HND_W;

    // stream widths
    localparam int S_TDATA_W    = 48;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 24;
    localparam int M_TUSER_W    = STATUS_W;

    // reserved key (all ones), rejected by lph_probe
    localparam logic [KEY_W-1:0] RESERVED_KEY = '1;

    // commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RESERVED  = 3'd4;

    // one slot always stays empty
    localparam logic [CNT_W-1:0] FULL_LIMIT = CNT_W'(TABLE_SLOTS - 1);

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [HND_W-1:0]        handler_out;
    } lph_res_t;

    // home slot: magnitude of the key modulo the table size
    function automatic slot_idx_t home_slot(input logic [KEY_W-1:0] key);
        slot_idx_t lo;
        lo = key[SLOT_W-1:0];
        return key[KEY_W-1] ? slot_idx_t'(~lo + SLOT_W'(1)) : lo;
    endfunction

    // next slot with wrap round the table
    function automatic slot_idx_t next_slot(input slot_idx_t s);
        return (s == slot_idx_t'(TABLE_SLOTS - 1)) ? '0 : s + slot_idx_t'(1);
    endfunction

    // slot index as carried in the result field
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input slot_idx_t s);
        return SLOT_FIELD_W'(s);
    endfunction

endpackage

FILE: rtl/linear_probe_hash_table.sv
// linear probe hash table: one item in flight, accepted only while the sequencer is idle
// insert: accept, probe from the home slot to the first empty slot, hand-off; no probes if full or reserved
// lookup: accept, read/compare from the home slot round the table (one RAM read per slot), hand-off
// result beat valid the cycle after hand-off; a new item is taken only once the last result is handed off
// reset clears valid bits and used count at once; entry RAM contents are left as they are
// depends on lph_pkg, lph_ram, lph_probe, lph_out
`timescale 1ns / 1ps

module linear_probe_hash_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lph_pkg::S_TDATA_W-1:0] s_axis_tdata,  // key[31:0], handler[47:32]
    input  logic [lph_pkg::S_TUSER_W-1:0] s_axis_tuser,  // cmd[0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lph_pkg::M_TDATA_W-1:0] m_axis_tdata,  // slot[5:0], handler_out[21:6], zero
    output logic [lph_pkg::M_TUSER_W-1:0] m_axis_tuser   // status[2:0]
);

    import lph_pkg::*;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    lph_res_t          res;

    // entry store: key and handler per slot
    lph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // probe sequencer
    lph_probe u_probe (
        .clk        (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser[0]),
        .in_key     (s_axis_tdata[KEY_W-1:0]),
        .in_handler (s_axis_tdata[KEY_W+HND_W-1:KEY_W]),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register
    lph_out u_out (
        .clk           (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/lph_ram.sv
// lph_ram: generic single-write, single-read synchronous RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lph_probe.sv
// lph_probe: probe sequencer with slot valid bits and used count, walks the entry RAM
// depends on lph_pkg; drives an lph_ram holding {key, handler} per slot
`timescale 1ns / 1ps

module lph_probe (
    input  logic                        clk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_cmd,
    input  logic [lph_pkg::KEY_W-1:0]   in_key,
    input  logic [lph_pkg::HND_W-1:0]   in_handler,
    output logic                        ram_we,
    output logic [lph_pkg::SLOT_W-1:0]  ram_waddr,
    output logic [lph_pkg::ENTRY_W-1:0] ram_wdata,
    output logic [lph_pkg::SLOT_W-1:0]  ram_raddr,
    input  logic [lph_pkg::ENTRY_W-1:0] ram_rdata,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lph_pkg::lph_res_t           res
);

    import lph_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;
    localparam logic [1:0] S_POST = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [HND_W-1:0]       hnd_reg, hnd_next;
    slot_idx_t              probe_reg, probe_next;
    cnt_t                   issue_cnt_reg, issue_cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    slot_idx_t              cmp_slot_reg, cmp_slot_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    cnt_t                   used_reg, used_next;
    lph_res_t               res_reg, res_next;

    logic hit;
    logic issuing;

    // compare stage sees the entry read in the previous cycle
    assign hit     = cmp_vld_reg && valid_reg[cmp_slot_reg]
                     && (ram_rdata[ENTRY_W-1:HND_W] == key_reg);
    assign issuing = (issue_cnt_reg != cnt_t'(TABLE_SLOTS));

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_POST);
    assign res       = res_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        hnd_next       = hnd_reg;
        probe_next     = probe_reg;
        issue_cnt_next = issue_cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        valid_next     = valid_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = probe_reg;
        ram_wdata      = {key_reg, hnd_reg};
        ram_raddr      = probe_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    key_next       = in_key;
                    hnd_next       = in_handler;
                    probe_next     = home_slot(in_key);
                    issue_cnt_next = '0;
                    if (in_key == RESERVED_KEY) begin
                        res_next   = '{status: ST_RESERVED, slot: '0, handler_out: '0};
                        state_next = S_POST;
                    end else if (in_cmd == CMD_INSERT) begin
                        if (used_reg >= FULL_LIMIT) begin
                            res_next   = '{status: ST_FULL, slot: '0, handler_out: '0};
                            state_next = S_POST;
                        end else begin
                            state_next = S_INS;
                        end
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_INS: begin
                // first empty slot from home takes the entry
                if (!valid_reg[probe_reg]) begin
                    ram_we                = 1'b1;
                    valid_next[probe_reg] = 1'b1;
                    used_next             = used_reg + cnt_t'(1);
                    res_next   = '{status: ST_INSERTED, slot: slot_field(probe_reg),
                                   handler_out: '0};
                    state_next = S_POST;
                end else begin
                    probe_next = next_slot(probe_reg);
                end
            end
            S_LOOK: begin
                // one read issued and one compare per cycle, at most one full circle
                cmp_vld_next  = issuing;
                cmp_slot_next = probe_reg;
                if (issuing) begin
                    probe_next     = next_slot(probe_reg);
                    issue_cnt_next = issue_cnt_reg + cnt_t'(1);
                end
                if (hit) begin
                    cmp_vld_next = 1'b0;
                    res_next     = '{status: ST_FOUND, slot: slot_field(cmp_slot_reg),
                                     handler_out: ram_rdata[HND_W-1:0]};
                    state_next   = S_POST;
                end else if (!issuing) begin
                    res_next   = '{status: ST_NOT_FOUND, slot: '0, handler_out: '0};
                    state_next = S_POST;
                end
            end
            S_POST: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            valid_reg   <= '0;
            used_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            valid_reg   <= valid_next;
            used_reg    <= used_next;
        end
    end

    // payload
    always_ff @(posedge clk) begin
        key_reg       <= key_next;
        hnd_reg       <= hnd_next;
        probe_reg     <= probe_next;
        issue_cnt_reg <= issue_cnt_next;
        cmp_slot_reg  <= cmp_slot_next;
        res_reg       <= res_next;
    end

endmodule

FILE: rtl/lph_out.sv
// lph_out: result output register for the master stream side
// depends on lph_pkg for the result struct and stream widths
`timescale 1ns / 1ps

module lph_out (
    input  logic                          clk,
    input  logic                          aresetn,
    input  logic                          res_valid,
    output logic                          res_ready,
    input  lph_pkg::lph_res_t             res,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lph_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [lph_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    import lph_pkg::*;

    logic                          valid_reg;
    logic [SLOT_FIELD_W+HND_W-1:0] data_reg;
    logic [STATUS_W-1:0]           status_reg;

    // register is free once empty or being drained
    assign res_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    // beat payload
    always_ff @(posedge clk) begin
        if (res_ready && res_valid) begin
            data_reg   <= {res.handler_out, res.slot};
            status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(data_reg);
    assign m_axis_tuser  = status_reg;

endmodule

FILE: rtl/lph_chk.sv
// lph_chk: port-level assertions for the linear probe hash table, bound to the top level
// depends on lph_pkg and linear_probe_hash_table
`timescale 1ns / 1ps

module lph_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lph_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [lph_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    import lph_pkg::*;

    // out of reset the block is empty and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // handler field only carries data on a hit
    a_hnd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != ST_FOUND) |->
            m_axis_tdata[SLOT_FIELD_W+HND_W-1:SLOT_FIELD_W] == '0)
        else $error("handler field set without a hit");

    // slot field zero when no slot was written or found
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOT_FOUND
                          || m_axis_tuser == ST_RESERVED) |->
            m_axis_tdata[SLOT_FIELD_W-1:0] == '0)
        else $error("slot field set without a slot");

endmodule

bind linear_probe_hash_table lph_chk u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
